[sv/pbb_pkg.sv]
// Shared types, constants and arithmetic helpers for the particle box bounce block.
`timescale 1ns / 1ps

package pbb_pkg;

  localparam int QW = 32;
  localparam int DtW = 17;
  localparam int BfW = 17;
  localparam int IdxW = 3;
  localparam int PipeDepth = 5;

  localparam logic signed [20:0] GravityQ = -21'sd642908;
  localparam logic signed [31:0] RadiusQ = 32'sd6554;

  localparam logic [DtW-1:0] TimeStepReset = 17'd1092;
  localparam logic signed [QW-1:0] BoxMinReset = -32'sd65536;
  localparam logic signed [QW-1:0] BoxMaxReset = 32'sd65536;
  localparam logic [BfW-1:0] BounceReset = 17'd52429;

  typedef logic signed [QW-1:0] q_t;

  typedef enum logic [IdxW-1:0] {
    RegTimeStep,
    RegBoxMinX,
    RegBoxMinY,
    RegBoxMinZ,
    RegBoxMaxX,
    RegBoxMaxY,
    RegBoxMaxZ,
    RegBounceFactor
  } reg_idx_e;

  typedef struct packed {
    q_t pos_x;
    q_t pos_y;
    q_t pos_z;
    q_t vel_x;
    q_t vel_y;
    q_t vel_z;
  } item_t;

  typedef struct packed {
    q_t new_pos_x;
    q_t new_pos_y;
    q_t new_pos_z;
    q_t new_vel_x;
    q_t new_vel_y;
    q_t new_vel_z;
    logic [2:0] bounce_mask;
  } result_t;

  typedef struct packed {
    logic [DtW-1:0] time_step;
    q_t box_min_x;
    q_t box_min_y;
    q_t box_min_z;
    q_t box_max_x;
    q_t box_max_y;
    q_t box_max_z;
    logic [BfW-1:0] bounce_factor;
  } cfg_t;

  function automatic logic signed [63:0] sx32(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  // Divide by 2^16, rounding to nearest with ties towards plus infinity.
  function automatic logic signed [63:0] rnd16(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + 64'sd32768;
    return t >>> 16;
  endfunction

  function automatic q_t sat_q(input logic signed [63:0] v);
    q_t r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[sv/pbb_cfg.sv]
// Configuration register file for the particle box bounce block.
`timescale 1ns / 1ps

module pbb_cfg (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   wr_en_i,
  input  logic [pbb_pkg::IdxW-1:0] wr_idx_i,
  input  logic [31:0]            wr_data_i,
  output pbb_pkg::cfg_t          cfg_o
);

  pbb_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.time_step     <= pbb_pkg::TimeStepReset;
      cfg_q.box_min_x     <= pbb_pkg::BoxMinReset;
      cfg_q.box_min_y     <= pbb_pkg::BoxMinReset;
      cfg_q.box_min_z     <= pbb_pkg::BoxMinReset;
      cfg_q.box_max_x     <= pbb_pkg::BoxMaxReset;
      cfg_q.box_max_y     <= pbb_pkg::BoxMaxReset;
      cfg_q.box_max_z     <= pbb_pkg::BoxMaxReset;
      cfg_q.bounce_factor <= pbb_pkg::BounceReset;
    end else if (wr_en_i) begin
      case (pbb_pkg::reg_idx_e'(wr_idx_i))
        pbb_pkg::RegTimeStep:     cfg_q.time_step <= wr_data_i[pbb_pkg::DtW-1:0];
        pbb_pkg::RegBoxMinX:      cfg_q.box_min_x <= wr_data_i;
        pbb_pkg::RegBoxMinY:      cfg_q.box_min_y <= wr_data_i;
        pbb_pkg::RegBoxMinZ:      cfg_q.box_min_z <= wr_data_i;
        pbb_pkg::RegBoxMaxX:      cfg_q.box_max_x <= wr_data_i;
        pbb_pkg::RegBoxMaxY:      cfg_q.box_max_y <= wr_data_i;
        pbb_pkg::RegBoxMaxZ:      cfg_q.box_max_z <= wr_data_i;
        pbb_pkg::RegBounceFactor: cfg_q.bounce_factor <= wr_data_i[pbb_pkg::BfW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

[sv/pbb_grav.sv]
// Two pipeline stages that apply gravity to the y velocity of each particle.
`timescale 1ns / 1ps

module pbb_grav (
  input  logic                      clk_i,
  input  pbb_pkg::item_t            item_i,
  input  logic [pbb_pkg::DtW-1:0]   time_step_i,
  output pbb_pkg::item_t            item_o
);

  pbb_pkg::item_t     item1_q, item2_q, item2_d;
  logic signed [37:0] gprod_q, gprod_d;
  logic signed [63:0] vy_sum;

  assign gprod_d = pbb_pkg::GravityQ * $signed({1'b0, time_step_i});

  always_comb begin
    vy_sum = pbb_pkg::sx32(item1_q.vel_y)
           + pbb_pkg::rnd16({{26{gprod_q[37]}}, gprod_q});
    item2_d = item1_q;
    item2_d.vel_y = pbb_pkg::sat_q(vy_sum);
  end

  always_ff @(posedge clk_i) begin
    item1_q <= item_i;
    gprod_q <= gprod_d;
    item2_q <= item2_d;
  end

  assign item_o = item2_q;

endmodule

[sv/pbb_axis.sv]
// Three pipeline stages that move one axis of a particle and reflect it off the walls.
`timescale 1ns / 1ps

module pbb_axis (
  input  logic                    clk_i,
  input  pbb_pkg::q_t             pos_i,
  input  pbb_pkg::q_t             vel_i,
  input  logic [pbb_pkg::DtW-1:0] time_step_i,
  input  logic [pbb_pkg::BfW-1:0] bounce_i,
  input  pbb_pkg::q_t             box_min_i,
  input  pbb_pkg::q_t             box_max_i,
  output pbb_pkg::q_t             pos_o,
  output pbb_pkg::q_t             vel_o,
  output logic                    hit_o
);

  logic signed [32:0] neg_vel;
  logic signed [49:0] pm_q, pm_d;
  logic signed [50:0] rm_q, rm_d;
  pbb_pkg::q_t        pos3_q, vel3_q;
  pbb_pkg::q_t        pos4_q, pos4_d, rv4_q, rv4_d, vel4_q;
  pbb_pkg::q_t        pos5_q, pos5_d, vel5_q, vel5_d;
  logic               hit5_q, hit5_d;
  logic signed [63:0] p_ext, r_ext;
  logic               lo_hit, hi_hit;

  assign neg_vel = -$signed({vel_i[31], vel_i});
  assign pm_d = $signed(vel_i) * $signed({1'b0, time_step_i});
  assign rm_d = neg_vel * $signed({1'b0, bounce_i});

  assign pos4_d = pbb_pkg::sat_q(pbb_pkg::sx32(pos3_q)
                + pbb_pkg::rnd16({{14{pm_q[49]}}, pm_q}));
  assign rv4_d = pbb_pkg::sat_q(pbb_pkg::rnd16({{13{rm_q[50]}}, rm_q}));

  always_comb begin
    p_ext  = pbb_pkg::sx32(pos4_q);
    r_ext  = pbb_pkg::sx32(pbb_pkg::RadiusQ);
    lo_hit = (p_ext - r_ext) < pbb_pkg::sx32(box_min_i);
    hi_hit = (p_ext + r_ext) > pbb_pkg::sx32(box_max_i);
    pos5_d = pos4_q;
    vel5_d = vel4_q;
    hit5_d = 1'b0;
    if (lo_hit) begin
      pos5_d = pbb_pkg::sat_q(pbb_pkg::sx32(box_min_i) + r_ext);
      vel5_d = rv4_q;
      hit5_d = 1'b1;
    end else if (hi_hit) begin
      pos5_d = pbb_pkg::sat_q(pbb_pkg::sx32(box_max_i) - r_ext);
      vel5_d = rv4_q;
      hit5_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    pos3_q <= pos_i;
    vel3_q <= vel_i;
    pm_q   <= pm_d;
    rm_q   <= rm_d;
    pos4_q <= pos4_d;
    rv4_q  <= rv4_d;
    vel4_q <= vel3_q;
    pos5_q <= pos5_d;
    vel5_q <= vel5_d;
    hit5_q <= hit5_d;
  end

  assign pos_o = pos5_q;
  assign vel_o = vel5_q;
  assign hit_o = hit5_q;

endmodule

[sv/particle_euler_box_bounce.sv]
// Top level of the particle box bounce block: config port, gravity stages and three axis lanes.
`timescale 1ns / 1ps

// The block takes one particle per clock cycle and never raises busy. Each result appears on
// res_o with res_valid_o high for one cycle, once the beat on start has passed through the five
// register stages around the gravity product, the time-step and bounce
// multipliers and the wall test. Results come out in the order particles went in and cannot be
// held off, so the receiver must take one every cycle. Configuration writes are always ready
// and should be made only while no particle is in flight.

module particle_euler_box_bounce (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  pbb_pkg::item_t            item_i,
  output logic                      res_valid_o,
  output pbb_pkg::result_t          res_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [pbb_pkg::IdxW-1:0]  cfg_index_i,
  input  logic [31:0]               cfg_data_i
);

  pbb_pkg::cfg_t  cfg;
  pbb_pkg::item_t grav_item;
  logic           accept;
  logic [pbb_pkg::PipeDepth-1:0] vld_q, vld_d;

  assign busy = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept = start && !busy;

  pbb_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i && cfg_ready_o),
    .wr_idx_i  (cfg_index_i),
    .wr_data_i (cfg_data_i),
    .cfg_o     (cfg)
  );

  pbb_grav u_grav (
    .clk_i       (clk_i),
    .item_i      (item_i),
    .time_step_i (cfg.time_step),
    .item_o      (grav_item)
  );

  pbb_axis u_axis_x (
    .clk_i       (clk_i),
    .pos_i       (grav_item.pos_x),
    .vel_i       (grav_item.vel_x),
    .time_step_i (cfg.time_step),
    .bounce_i    (cfg.bounce_factor),
    .box_min_i   (cfg.box_min_x),
    .box_max_i   (cfg.box_max_x),
    .pos_o       (res_o.new_pos_x),
    .vel_o       (res_o.new_vel_x),
    .hit_o       (res_o.bounce_mask[0])
  );

  pbb_axis u_axis_y (
    .clk_i       (clk_i),
    .pos_i       (grav_item.pos_y),
    .vel_i       (grav_item.vel_y),
    .time_step_i (cfg.time_step),
    .bounce_i    (cfg.bounce_factor),
    .box_min_i   (cfg.box_min_y),
    .box_max_i   (cfg.box_max_y),
    .pos_o       (res_o.new_pos_y),
    .vel_o       (res_o.new_vel_y),
    .hit_o       (res_o.bounce_mask[1])
  );

  pbb_axis u_axis_z (
    .clk_i       (clk_i),
    .pos_i       (grav_item.pos_z),
    .vel_i       (grav_item.vel_z),
    .time_step_i (cfg.time_step),
    .bounce_i    (cfg.bounce_factor),
    .box_min_i   (cfg.box_min_z),
    .box_max_i   (cfg.box_max_z),
    .pos_o       (res_o.new_pos_z),
    .vel_o       (res_o.new_vel_z),
    .hit_o       (res_o.bounce_mask[2])
  );

  assign vld_d = {vld_q[pbb_pkg::PipeDepth-2:0], accept};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign res_valid_o = vld_q[pbb_pkg::PipeDepth-1];

  // Every result beat traces back to an accepted particle, and every accepted particle
  // produces one.
  a_res_from_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(accept, pbb_pkg::PipeDepth))
    else $error("result beat without a matching accepted particle");

  a_accept_gives_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##(pbb_pkg::PipeDepth) res_valid_o)
    else $error("accepted particle produced no result beat");

  // An x bounce places the particle just inside one of the x walls.
  a_x_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.bounce_mask[0]) |->
      (res_o.new_pos_x == pbb_pkg::sat_q(pbb_pkg::sx32(cfg.box_min_x)
                                        + pbb_pkg::sx32(pbb_pkg::RadiusQ))) ||
      (res_o.new_pos_x == pbb_pkg::sat_q(pbb_pkg::sx32(cfg.box_max_x)
                                        - pbb_pkg::sx32(pbb_pkg::RadiusQ))))
    else $error("x bounce left the position off both wall clamps");

  // Without an x bounce the x velocity passes through unchanged.
  a_x_vel_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.bounce_mask[0]) |->
      res_o.new_vel_x == $past(item_i.vel_x, pbb_pkg::PipeDepth))
    else $error("x velocity changed without a bounce");

endmodule
